// ===== hw/rtl/tra_pkg.sv =====
`timescale 1ns / 1ps

package tra_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_NUM   = 3;
  localparam int REG_IDX_W = 2;
  localparam int FUNC_W    = 3;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  typedef enum logic [FUNC_W-1:0] {
    FN_MOV = 3'd0,
    FN_ADD = 3'd1,
    FN_SUB = 3'd2,
    FN_MUL = 3'd3,
    FN_DIV = 3'd4,
    FN_AND = 3'd5,
    FN_OR  = 3'd6,
    FN_NOP = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    SRC_IMM  = 2'd0,
    SRC_REG  = 2'd1,
    SRC_ZERO = 2'd2
  } src_kind_t;

  typedef struct packed {
    func_t                 op;
    logic                  dest_ok;
    logic [REG_IDX_W-1:0]  dest_idx;
    src_kind_t             src_kind;
    logic [REG_IDX_W-1:0]  src_idx;
    logic [DATA_W-1:0]     imm;
  } dec_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_st_t;

  typedef struct packed {
    logic pop;
    logic div_start;
    logic div_busy;
  } back_stat_t;

endpackage

// ===== hw/rtl/tra_if.sv =====
`timescale 1ns / 1ps

interface tra_in_if import tra_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [FUNC_W-1:0]           func;
  logic [REG_IDX_W-1:0]        dest_reg;
  logic                        src_is_reg;
  logic [REG_IDX_W-1:0]        src_reg;
  logic signed [DATA_W-1:0]    immediate;

  modport source (output valid, func, dest_reg, src_is_reg, src_reg, immediate,
                  input ready);
  modport sink   (input valid, func, dest_reg, src_is_reg, src_reg, immediate,
                  output ready);
endinterface

interface tra_out_if import tra_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_W-1:0]    dest_value;
  logic                        div_zero_error;

  modport source (output valid, dest_value, div_zero_error, input ready);
  modport sink   (input valid, dest_value, div_zero_error, output ready);
endinterface

// ===== hw/rtl/three_register_alu_executor.sv =====
`timescale 1ns / 1ps
// throughput, while out_ch is not stalled and no divide runs:
// one word per cycle for mov/add/sub/mul/and/or and div by zero
// a divide holds the execute side for its 32 radix-2 divider steps
// the input side keeps filling the queue while a divide runs
// reset: synchronous active-low rst_n clears r1..r3, the queue and out_valid

module three_register_alu_executor import tra_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  tra_in_if.sink    in_ch,
  tra_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             push_valid, push_ready;
  dec_t             push_data;
  logic             q_valid, q_pop;
  dec_t             q_data;
  logic [CNT_W-1:0] q_cnt;
  back_stat_t       stat;

  tra_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data),
    .count      (q_cnt)
  );

  tra_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !stat.pop) |=> q_cnt == $past(q_cnt) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> q_cnt != '0)
    else $error("pop from empty queue");

  a_div_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> !stat.pop)
    else $error("pop while divider busy");

  a_pop_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.pop && !stat.div_start) |=> out_ch.valid)
    else $error("single-cycle op produced no result word");

endmodule

// ===== hw/rtl/tra_front.sv =====
`timescale 1ns / 1ps

module tra_front import tra_pkg::*; (
  tra_in_if.sink  in_ch,
  output logic    push_valid,
  input  logic    push_ready,
  output dec_t    push_data
);

  always_comb begin
    push_data          = '0;
    push_data.op       = func_t'(in_ch.func);
    push_data.dest_ok  = in_ch.dest_reg < REG_IDX_W'(REG_NUM);
    push_data.dest_idx = in_ch.dest_reg;
    push_data.src_idx  = in_ch.src_reg;
    push_data.imm      = in_ch.immediate;
    if (!in_ch.src_is_reg) begin
      push_data.src_kind = SRC_IMM;
    end else if (in_ch.src_reg < REG_IDX_W'(REG_NUM)) begin
      push_data.src_kind = SRC_REG;
    end else begin
      push_data.src_kind = SRC_ZERO;
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

// ===== hw/rtl/tra_queue.sv =====
`timescale 1ns / 1ps

module tra_queue import tra_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  dec_t                         push_data,
  output logic                         pop_valid,
  input  logic                         pop,
  output dec_t                         pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign count      = cnt_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/tra_back.sv =====
`timescale 1ns / 1ps

module tra_back import tra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  dec_t        q_data,
  output logic        q_pop,
  tra_out_if.source   out_ch,
  output back_stat_t  stat
);

  back_st_t              st_r, st_nxt;
  logic [DATA_W-1:0]     rf_r [REG_NUM];
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]     quo_r, quo_nxt;
  logic [DATA_W-1:0]     dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [REG_IDX_W-1:0]  didx_r, didx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_value_r, out_value_nxt;
  logic                  out_err_r, out_err_nxt;

  logic                  slot_free;
  logic [DATA_W-1:0]     src_val, dst_val, alu_res, mul_lo, q_final;
  logic [DATA_W:0]       shifted, diff;
  logic                  ge, src_zero, div_start;
  logic                  rf_we;
  logic [REG_IDX_W-1:0]  rf_widx;
  logic [DATA_W-1:0]     rf_wdata;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = (st_r == ST_IDLE) && q_valid && slot_free;

  always_comb begin
    case (q_data.src_kind)
      SRC_IMM:  src_val = q_data.imm;
      SRC_REG:  src_val = rf_r[q_data.src_idx];
      SRC_ZERO: src_val = '0;
      default:  src_val = '0;
    endcase
  end

  assign dst_val   = q_data.dest_ok ? rf_r[q_data.dest_idx] : '0;
  assign mul_lo    = dst_val * src_val;
  assign src_zero  = src_val == '0;
  assign div_start = q_pop && q_data.dest_ok && (q_data.op == FN_DIV) && !src_zero;

  always_comb begin
    case (q_data.op)
      FN_MOV:  alu_res = src_val;
      FN_ADD:  alu_res = dst_val + src_val;
      FN_SUB:  alu_res = dst_val - src_val;
      FN_MUL:  alu_res = mul_lo;
      FN_AND:  alu_res = dst_val & src_val;
      FN_OR:   alu_res = dst_val | src_val;
      default: alu_res = dst_val;
    endcase
  end

  // restoring divider step on magnitudes
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = !diff[DATA_W];
  assign q_final = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_comb begin
    st_nxt        = st_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    rf_we         = 1'b0;
    rf_widx       = q_data.dest_idx;
    rf_wdata      = alu_res;
    case (st_r)
      ST_IDLE: begin
        if (div_start) begin
          quo_nxt  = dst_val[DATA_W-1] ? (~dst_val + 1'b1) : dst_val;
          dvs_nxt  = src_val[DATA_W-1] ? (~src_val + 1'b1) : src_val;
          rem_nxt  = '0;
          neg_nxt  = dst_val[DATA_W-1] ^ src_val[DATA_W-1];
          cnt_nxt  = '0;
          didx_nxt = q_data.dest_idx;
          st_nxt   = ST_DIV;
        end else if (q_pop) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = q_data.dest_ok ? alu_res : '0;
          out_err_nxt   = q_data.dest_ok && (q_data.op == FN_DIV);
          rf_we         = q_data.dest_ok;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = q_final;
          out_err_nxt   = 1'b0;
          rf_we         = 1'b1;
          rf_widx       = didx_r;
          rf_wdata      = q_final;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_NUM; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_r[rf_widx] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dvs_r       <= dvs_nxt;
    neg_r       <= neg_nxt;
    cnt_r       <= cnt_nxt;
    didx_r      <= didx_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.dest_value     = out_value_r;
  assign out_ch.div_zero_error = out_err_r;

  assign stat.pop       = q_pop;
  assign stat.div_start = div_start;
  assign stat.div_busy  = st_r != ST_IDLE;

endmodule
